>>> sv/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// S-boxes, GF(2^8) helpers and round transforms shared by the cipher files.
// ----------------------------------------------------------------------------
package aes_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   byte_t;

  localparam int NumRounds = 10;
  localparam logic FuncEnc = 1'b0;
  localparam logic FuncDec = 1'b1;
  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow  = 1'b1;

  typedef struct packed {
    logic valid;
    logic func;
  } ctl_t;

  function automatic byte_t sbox(input byte_t a);
    byte_t r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b; 8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b; 8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d; 8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf; 8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26; 8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1; 8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3; 8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2; 8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a; 8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3; 8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed; 8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39; 8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb; 8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f; 8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f; 8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21; 8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec; 8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d; 8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc; 8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14; 8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a; 8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62; 8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d; 8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea; 8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e; 8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f; 8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66; 8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9; 8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11; 8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9; 8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d; 8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f; 8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // inverse box as a fixed lookup table
  function automatic byte_t inv_sbox(input byte_t a);
    byte_t r;
    case (a)
      8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5; 8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
      8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e; 8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
      8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82; 8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
      8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44; 8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
      8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32; 8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
      8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b; 8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
      8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66; 8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
      8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49; 8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
      8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64; 8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
      8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc; 8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
      8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50; 8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
      8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57; 8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
      8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00; 8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
      8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05; 8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
      8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f; 8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
      8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03; 8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
      8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41; 8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
      8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce; 8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
      8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22; 8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
      8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8; 8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
      8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71; 8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
      8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e; 8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
      8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b; 8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
      8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe; 8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
      8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33; 8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
      8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59; 8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
      8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9; 8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
      8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f; 8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
      8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d; 8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
      8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c; 8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
      8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e; 8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
      8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63; 8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t xt(input byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t get_b(input blk_t s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = sbox(get_b(s, 4*((c+r)%4)+r));
      end
    end
    return t;
  endfunction

  function automatic blk_t inv_sub_shift(input blk_t s);
    blk_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*((c+r)%4)+r) -: 8] = inv_sbox(get_b(s, 4*c+r));
      end
    end
    return t;
  endfunction

  function automatic blk_t mix(input blk_t s);
    blk_t t;
    byte_t a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a0 = get_b(s, 4*c+r);
        a1 = get_b(s, 4*c+((r+1)%4));
        a2 = get_b(s, 4*c+((r+2)%4));
        a3 = get_b(s, 4*c+((r+3)%4));
        t[127-8*(4*c+r) -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      end
    end
    return t;
  endfunction

  // inverse mix: 0e,0b,0d,09 built from doublings
  function automatic blk_t inv_mix(input blk_t s);
    blk_t t;
    byte_t a0, a1, a2, a3, u, v;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a0 = get_b(s, 4*c+r);
        a1 = get_b(s, 4*c+((r+1)%4));
        a2 = get_b(s, 4*c+((r+2)%4));
        a3 = get_b(s, 4*c+((r+3)%4));
        u = xt(xt(a0 ^ a2));
        v = xt(xt(a1 ^ a3));
        t[127-8*(4*c+r) -: 8] = xt(a0 ^ a1) ^ a1 ^ a2 ^ a3 ^ u ^ xt(u ^ v);
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

>>> sv/aes_key_sched.sv
// ----------------------------------------------------------------------------
// AES key schedule
// Expands the key round by round after reset and after each key write; holds 11 round keys.
// ----------------------------------------------------------------------------
module aes_key_sched (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [127:0]       key,
  output aes_pkg::blk_t      rk [aes_pkg::NumRounds+1],
  output logic               busy
);
  import aes_pkg::*;

  logic [3:0]  rnd;
  logic [7:0]  rcon;
  blk_t        cur, nxt;
  logic [31:0] w0, w1, w2, w3, tw;

  always_comb begin
    tw = sub_word({cur[23:0], cur[31:24]}) ^ {rcon, 24'h0};
    w0 = cur[127:96] ^ tw;
    w1 = cur[95:64] ^ w0;
    w2 = cur[63:32] ^ w1;
    w3 = cur[31:0] ^ w2;
    nxt = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      rnd    <= 4'd1;
      rcon   <= 8'h01;
      busy   <= 1'b1;
      cur    <= rst ? '0 : key;
      rk[0]  <= rst ? '0 : key;
    end else if (busy) begin
      rk[rnd] <= nxt;
      cur     <= nxt;
      rcon    <= xt(rcon);
      rnd     <= rnd + 4'd1;
      if (rnd == 4'(NumRounds)) busy <= 1'b0;
    end
  end

endmodule

>>> sv/aes_round.sv
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher round for either direction.
// ----------------------------------------------------------------------------
module aes_round (
  input  logic          clk,
  input  logic          rst,
  input  logic          last,
  input  aes_pkg::ctl_t ctl_in,
  input  aes_pkg::blk_t st_in,
  input  aes_pkg::blk_t iv_in,
  input  aes_pkg::blk_t ekey,
  input  aes_pkg::blk_t dkey,
  output aes_pkg::ctl_t ctl_out,
  output aes_pkg::blk_t st_out,
  output aes_pkg::blk_t iv_out
);
  import aes_pkg::*;

  blk_t e, d;

  always_comb begin
    e = sub_shift(st_in);
    if (!last) e = mix(e);
    e = e ^ ekey;
    d = inv_sub_shift(st_in) ^ dkey;
    if (!last) d = inv_mix(d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.func <= ctl_in.func;
    st_out <= (ctl_in.func == FuncDec) ? d : e;
    iv_out <= iv_in;
  end

endmodule

>>> sv/aes128_cbc_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 CBC block cipher
// One transaction may start each cycle while busy is low.
// Input stage does encrypt chaining XOR and initial key add, ten round stages
// follow, output stage applies the decrypt chaining XOR. Reset clears the key
// to zero; busy is high during key expansion after reset or a key write.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module aes128_cbc_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic [63:0] iv_high,
  input  logic [63:0] iv_low,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic [63:0] out_high,
  output logic [63:0] out_low
);
  import aes_pkg::*;

  logic [63:0] key_high, key_low;
  blk_t        rk [NumRounds+1];
  logic        ks_busy;
  ctl_t        ctl [NumRounds+1];
  blk_t        st  [NumRounds+1];
  blk_t        ivp [NumRounds+1];
  blk_t        blk_in, iv_in, res;
  logic        acc;

  // key registers; schedule restarts on every write
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CfgKeyHigh) key_high <= cfg_data;
      else                         key_low  <= cfg_data;
    end
  end

  aes_key_sched u_ks (
    .clk  (clk),
    .rst  (rst),
    .load (cfg_we),
    .key  ({cfg_index == CfgKeyHigh ? cfg_data : key_high,
            cfg_index == CfgKeyLow  ? cfg_data : key_low}),
    .rk   (rk),
    .busy (ks_busy)
  );

  assign busy   = ks_busy;
  assign acc    = start && !busy;
  assign blk_in = {block_high, block_low};
  assign iv_in  = {iv_high, iv_low};

  // entry stage: encrypt pre-whitens with the chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= acc;
    end
    ctl[0].func <= func;
    st[0]  <= (func == FuncEnc) ? (blk_in ^ iv_in ^ rk[0]) : (blk_in ^ rk[NumRounds]);
    ivp[0] <= iv_in;
  end

  // round stage r uses key r encrypting, key 10-r decrypting
  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_round u_rnd (
      .clk     (clk),
      .rst     (rst),
      .last    (g == NumRounds),
      .ctl_in  (ctl[g-1]),
      .st_in   (st[g-1]),
      .iv_in   (ivp[g-1]),
      .ekey    (rk[g]),
      .dkey    (rk[NumRounds-g]),
      .ctl_out (ctl[g]),
      .st_out  (st[g]),
      .iv_out  (ivp[g])
    );
  end

  // exit stage: decrypt post-XORs the chaining value
  assign res = (ctl[NumRounds].func == FuncDec) ? (st[NumRounds] ^ ivp[NumRounds])
                                                : st[NumRounds];
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[NumRounds].valid;
    end
    out_high <= res[127:64];
    out_low  <= res[63:0];
  end

  // no transaction enters while round keys are being rebuilt
  a_no_acc_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> ##1 !ctl[0].valid) else $error("accepted during key expansion");
  // each accepted transaction comes out with done raised
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##12 done) else $error("result lost");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(start && !busy, 12)) else $error("spurious result");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 CBC block cipher testbench
// Known-answer vectors, then random encrypt/decrypt transactions under several
// keys, each result checked against its known answer or a behavioural AES model held here.
// ----------------------------------------------------------------------------
module testbench;
  import aes_pkg::*;

  // clock and reset
  logic clk;
  logic rst = 1'b1;

  // command side
  logic        start = 1'b0;
  logic        busy;
  logic        func = FuncEnc;
  logic [63:0] block_high = '0, block_low = '0, iv_high = '0, iv_low = '0;

  // key register port
  logic        cfg_we = 1'b0;
  logic        cfg_index = CfgKeyHigh;
  logic [63:0] cfg_data = '0;

  // result side
  logic        done;
  logic [63:0] out_high, out_low;

  aes128_cbc_block_cipher dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .block_high(block_high), .block_low(block_low),
    .iv_high(iv_high), .iv_low(iv_low),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .out_high(out_high), .out_low(out_low)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- model --
  byte_t  fwd_tab [256];
  byte_t  inv_tab [256];
  blk_t   round_key [11];   // round keys as held by the model
  logic [127:0] cipher_key;  // key_high in the upper half

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box from the field inverse plus the affine map
  function automatic byte_t affine_sub(input byte_t b);
    byte_t x, y;
    x = 8'h01;
    if (b != 0) for (int i = 0; i < 254; i++) x = gf_mul(x, b);
    else x = 8'h00;
    y = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]};
    return y ^ 8'h63;
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    byte_t rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = cipher_key[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]], fwd_tab[t[31:24]]};
        t[31:24] ^= rc;
        rc = gf_mul(rc, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  // byte n of a state sits at bits 127-8n
  function automatic blk_t shift_subst(input blk_t s, input logic inverse);
    blk_t t;
    int src, dst;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inverse) begin
          src = 4*c + r; dst = 4*((c+r)%4) + r;
          t[127-8*dst -: 8] = inv_tab[s[127-8*src -: 8]];
        end else begin
          src = 4*((c+r)%4) + r; dst = 4*c + r;
          t[127-8*dst -: 8] = fwd_tab[s[127-8*src -: 8]];
        end
      end
    return t;
  endfunction

  function automatic blk_t mix_cols(input blk_t s, input logic inverse);
    blk_t t;
    byte_t a [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[127-8*(4*c+r) -: 8];
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = inverse ?
          gf_mul(a[r], 8'h0e) ^ gf_mul(a[(r+1)%4], 8'h0b) ^
          gf_mul(a[(r+2)%4], 8'h0d) ^ gf_mul(a[(r+3)%4], 8'h09) :
          gf_mul(a[r], 8'h02) ^ gf_mul(a[(r+1)%4], 8'h03) ^ a[(r+2)%4] ^ a[(r+3)%4];
    end
    return t;
  endfunction

  function automatic blk_t cbc_step(input logic f, input blk_t blk, input blk_t iv);
    blk_t s;
    if (f == FuncEnc) begin
      s = blk ^ iv ^ round_key[0];
      for (int r = 1; r <= NumRounds; r++) begin
        s = shift_subst(s, 1'b0);
        if (r < NumRounds) s = mix_cols(s, 1'b0);
        s ^= round_key[r];
      end
    end else begin
      s = blk ^ round_key[NumRounds];
      for (int r = NumRounds - 1; r >= 0; r--) begin
        s = shift_subst(s, 1'b1) ^ round_key[r];
        if (r > 0) s = mix_cols(s, 1'b1);
      end
      s ^= iv;
    end
    return s;
  endfunction

  // ------------------------------------------------------------- checking --
  blk_t expected_blocks [$];
  int   n_fail = 0, n_checked = 0, n_sent = 0, n_keys = 0;

  always @(posedge clk) begin
    blk_t want;
    if (!rst && done) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: result %h%h with no transaction outstanding", $time, out_high, out_low);
        n_fail++;
      end else begin
        want = expected_blocks.pop_front();
        n_checked++;
        if (out_high !== want[127:64]) begin
          $display("%0t: out_high expected %h actual %h", $time, want[127:64], out_high);
          n_fail++;
        end
        if (out_low !== want[63:0]) begin
          $display("%0t: out_low expected %h actual %h", $time, want[63:0], out_low);
          n_fail++;
        end
      end
    end
  end

  // ------------------------------------------------------------ stimulus --
  // drive one transaction and hold it until the block takes it
  task automatic issue(input logic f, input blk_t blk, input blk_t iv, input blk_t known,
                       input logic use_known);
    blk_t model_out;
    start <= 1'b1; func <= f;
    block_high <= blk[127:64]; block_low <= blk[63:0];
    iv_high <= iv[127:64]; iv_low <= iv[63:0];
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    model_out = cbc_step(f, blk, iv);
    if (use_known && model_out !== known)
      $display("%0t: note, model gives %h for a known vector", $time, model_out);
    expected_blocks.push_back(use_known ? known : model_out);
    n_sent++;
  endtask

  task automatic idle_burst(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // key change only with the pipeline drained; each write starts an expansion
  task automatic load_key(input logic [127:0] k);
    start <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CfgKeyHigh; cfg_data <= k[127:64];
    @(posedge clk);
    cfg_we <= 1'b0;
    do @(posedge clk); while (busy);
    cfg_we <= 1'b1; cfg_index <= CfgKeyLow; cfg_data <= k[63:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cipher_key = k;
    expand_round_keys();
    n_keys++;
  endtask

  typedef struct {
    logic [127:0] key;
    logic         f;
    blk_t         blk;
    blk_t         iv;
    logic         known;
    blk_t         result;
  } vector_t;

  localparam blk_t Ones = {128{1'b1}};
  localparam logic [127:0] FipsKey = 128'h000102030405060708090a0b0c0d0e0f;
  localparam logic [127:0] Sp800Key = 128'h2b7e151628aed2a6abf7158809cf4f3c;

  vector_t vectors [] = '{
    // zero key as left by reset
    '{'0, FuncEnc, '0, '0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{'0, FuncDec, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, '0, 1'b1, '0},
    '{'0, FuncDec, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, Ones, 1'b1, Ones},
    '{'0, FuncEnc, Ones, Ones, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{'0, FuncEnc, Ones, '0, 1'b0, '0},
    '{'0, FuncDec, Ones, Ones, 1'b0, '0},
    // standard known answers
    '{FipsKey, FuncEnc, 128'h00112233445566778899aabbccddeeff, '0, 1'b1,
      128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{FipsKey, FuncDec, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, '0, 1'b1,
      128'h00112233445566778899aabbccddeeff},
    '{FipsKey, FuncEnc, '0, 128'h00112233445566778899aabbccddeeff, 1'b1,
      128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{Sp800Key, FuncEnc, 128'h3243f6a8885a308d313198a2e0370734, '0, 1'b1,
      128'h3925841d02dc09fbdc118597196a0b32},
    '{Sp800Key, FuncDec, 128'h3925841d02dc09fbdc118597196a0b32, '0, 1'b1,
      128'h3243f6a8885a308d313198a2e0370734},
    '{Sp800Key, FuncDec, '0, Ones, 1'b0, '0},
    // all-ones key
    '{Ones, FuncEnc, '0, '0, 1'b0, '0},
    '{Ones, FuncEnc, Ones, 128'h8000000000000001_8000000000000001, 1'b0, '0},
    '{Ones, FuncDec, Ones, '0, 1'b0, '0},
    '{Ones, FuncDec, 128'h0123456789abcdef_fedcba9876543210, Ones, 1'b0, '0}
  };

  function automatic blk_t rand_blk();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    blk_t blk, iv, last_ct;
    logic f;
    logic [127:0] k;
    int per_phase;

    for (int i = 0; i < 256; i++) fwd_tab[i] = affine_sub(byte_t'(i));
    for (int i = 0; i < 256; i++) inv_tab[fwd_tab[i]] = byte_t'(i);
    cipher_key = '0;
    expand_round_keys();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table, back to back within a key
    foreach (vectors[i]) begin
      if (vectors[i].key != cipher_key) load_key(vectors[i].key);
      issue(vectors[i].f, vectors[i].blk, vectors[i].iv, vectors[i].result, vectors[i].known);
    end

    // random phases: mostly CBC chains under one key, with loose transactions mixed in
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: k = '0;
        7: k = Ones;
        default: k = rand_blk();
      endcase
      load_key(k);
      per_phase = 50;
      last_ct = rand_blk();
      for (int n = 0; n < per_phase; n++) begin
        f = $urandom_range(0, 1);
        blk = rand_blk();
        // chain: chaining value is usually the previous ciphertext block
        iv = ($urandom_range(0, 3) != 0) ? last_ct : rand_blk();
        if ($urandom_range(0, 15) == 0) iv = $urandom_range(0, 1) ? Ones : '0;
        issue(f, blk, iv, '0, 1'b0);
        last_ct = (f == FuncEnc) ? cbc_step(f, blk, iv) : blk;
        // gaps in most phases, none in phase 3 or the closing ones
        if (phase < 6 && phase != 3 && $urandom_range(0, 3) == 0)
          idle_burst($urandom_range(1, 5));
      end
    end
    start <= 1'b0;

    fork
      while (expected_blocks.size() != 0) @(posedge clk);
      begin
        repeat (2000) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (20) @(posedge clk);

    $display("Sent %0d transactions under %0d key loads, %0d results checked.",
             n_sent, n_keys, n_checked);
    if (n_fail == 0 && expected_blocks.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (expected_blocks.size() != 0)
        $display("%0t: %0d results never arrived", $time, expected_blocks.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
